// ===== src/assert_macros.svh =====
// assertion macros shared by the range xor tree sources
// clocked on clk_i and held off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define RXST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// trigger on one edge implies a condition on the same edge
`define RXST_ASSERT_IMPL(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error(msg);

// trigger on one edge implies a condition on the next edge
`define RXST_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== src/rxst_pkg.sv =====
// shared constants and types of the range xor segment tree
// no dependencies; used by the node memory, the tree walker and the top level
package rxst_pkg;

  localparam int VALUE_BITS   = 32;
  localparam int IDX_BITS     = 10;
  localparam int CNT_BITS     = 11;
  localparam int MAX_ELEMENTS = 1024;
  localparam int TREE_NODES   = 4096;
  localparam int NODE_BITS    = 12;
  localparam int STACK_DEPTH  = 16;
  localparam int SP_BITS      = 4;

  // operation codes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // one tree node: segment xor and the mark still owed to it
  typedef struct packed {
    logic [VALUE_BITS-1:0] node;
    logic [VALUE_BITS-1:0] pend;
  } entry_t;

  // node memory access for one cycle
  typedef struct packed {
    logic                 re;
    logic [NODE_BITS-1:0] raddr;
    logic                 we;
    logic [NODE_BITS-1:0] waddr;
    entry_t               wdata;
  } mem_req_t;

endpackage

// ===== src/rxst_node_ram.sv =====
// single read, single write node memory with registered read data
// depends on rxst_pkg for the entry type and depth
module rxst_node_ram (
  input  logic               clk_i,
  input  rxst_pkg::mem_req_t req_i,
  output rxst_pkg::entry_t   rdata_o
);

  rxst_pkg::entry_t mem_q [rxst_pkg::TREE_NODES];
  rxst_pkg::entry_t rdata_q;

  // write port and read port, read returns the old word on a clash
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/rxst_walker.sv =====
// tree walker: clears the node memory, then walks the tree for each word
// with an explicit frame stack; depends on rxst_pkg
module rxst_walker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            op_i,
  input  logic [rxst_pkg::IDX_BITS-1:0]   left_i,
  input  logic [rxst_pkg::IDX_BITS-1:0]   right_i,
  input  logic [rxst_pkg::VALUE_BITS-1:0] value_i,
  input  logic [rxst_pkg::IDX_BITS-1:0]   last_i,
  output logic                            busy_o,
  output logic                            res_valid_o,
  output logic [rxst_pkg::VALUE_BITS-1:0] res_data_o,
  output rxst_pkg::mem_req_t              mem_req_o,
  input  rxst_pkg::entry_t                mem_rdata_i
);

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_READ   = 8'b0000_0100,
    ST_EVAL   = 8'b0000_1000,
    ST_PUSH0  = 8'b0001_0000,
    ST_PUSH1  = 8'b0010_0000,
    ST_DECIDE = 8'b0100_0000,
    ST_RET    = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic [rxst_pkg::NODE_BITS-1:0]  k;
    logic [rxst_pkg::IDX_BITS-1:0]   lo;
    logic [rxst_pkg::IDX_BITS-1:0]   hi;
    logic [rxst_pkg::VALUE_BITS-1:0] acc;
    logic                            ph;
  } frame_t;

  state_e                          state_q, state_d;
  logic [rxst_pkg::NODE_BITS-1:0]  clr_q, clr_d;
  logic                            op_q, op_d;
  logic [rxst_pkg::IDX_BITS-1:0]   l_q, l_d, r_q, r_d;
  logic [rxst_pkg::VALUE_BITS-1:0] v_q, v_d;
  logic [rxst_pkg::NODE_BITS-1:0]  k_q, k_d;
  logic [rxst_pkg::IDX_BITS-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic [rxst_pkg::SP_BITS-1:0]    sp_q, sp_d;
  logic [rxst_pkg::VALUE_BITS-1:0] t_q, t_d, nv_q, nv_d, ret_q, ret_d;
  logic                            out_q, out_d, cov_q, cov_d;
  logic                            res_valid_q, res_valid_d;
  logic [rxst_pkg::VALUE_BITS-1:0] res_q, res_d;
  frame_t                          stk_q [rxst_pkg::STACK_DEPTH];

  logic                            stk_we;
  logic [rxst_pkg::SP_BITS-1:0]    stk_wa, sp_top;
  frame_t                          stk_wd, top;
  logic                            out_c, cov_c, leaf, odd;
  logic [rxst_pkg::VALUE_BITS-1:0] t_c, nv_c, acc_c;
  logic [rxst_pkg::IDX_BITS:0]     sum_c, tsum_c;
  logic [rxst_pkg::IDX_BITS-1:0]   mid_c, tmid_c;
  logic [rxst_pkg::NODE_BITS-1:0]  kl_c, kr_c;
  rxst_pkg::mem_req_t              req;

  // node evaluation on the word just read
  assign out_c  = (r_q < lo_q) || (hi_q < l_q);
  assign cov_c  = (l_q <= lo_q) && (hi_q <= r_q);
  assign leaf   = (lo_q == hi_q);
  assign odd    = (lo_q[0] == hi_q[0]);
  assign t_c    = ((op_q == rxst_pkg::OP_UPDATE) && cov_c) ? (mem_rdata_i.pend ^ v_q)
                                                           : mem_rdata_i.pend;
  assign nv_c   = odd ? (mem_rdata_i.node ^ t_c) : mem_rdata_i.node;
  assign sum_c  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_c  = sum_c[rxst_pkg::IDX_BITS:1];
  assign kl_c   = {k_q[rxst_pkg::NODE_BITS-2:0], 1'b0};
  assign kr_c   = {k_q[rxst_pkg::NODE_BITS-2:0], 1'b1};

  // parent frame on top of the stack
  assign sp_top = sp_q - 1'b1;
  assign top    = stk_q[sp_top];
  assign acc_c  = top.acc ^ ret_q;
  assign tsum_c = {1'b0, top.lo} + {1'b0, top.hi};
  assign tmid_c = tsum_c[rxst_pkg::IDX_BITS:1];

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    op_d        = op_q;
    l_d         = l_q;
    r_d         = r_q;
    v_d         = v_q;
    k_d         = k_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    sp_d        = sp_q;
    t_d         = t_q;
    nv_d        = nv_q;
    ret_d       = ret_q;
    out_d       = out_q;
    cov_d       = cov_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    stk_we      = 1'b0;
    stk_wa      = sp_q;
    stk_wd      = '0;
    req         = '0;
    unique case (state_q)
      ST_CLEAR: begin
        req.we    = 1'b1;
        req.waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          op_d    = op_i;
          l_d     = left_i;
          r_d     = right_i;
          v_d     = value_i;
          k_d     = rxst_pkg::NODE_BITS'(1);
          lo_d    = '0;
          hi_d    = last_i;
          sp_d    = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        req.re    = 1'b1;
        req.raddr = k_q;
        state_d   = ST_EVAL;
      end
      ST_EVAL: begin
        req.we         = 1'b1;
        req.waddr      = k_q;
        req.wdata.node = nv_c;
        t_d            = t_c;
        nv_d           = nv_c;
        out_d          = out_c;
        cov_d          = cov_c;
        if (!leaf && (t_c != '0)) begin
          req.re    = 1'b1;
          req.raddr = kl_c;
          state_d   = ST_PUSH0;
        end else begin
          state_d = ST_DECIDE;
        end
      end
      ST_PUSH0: begin
        req.we         = 1'b1;
        req.waddr      = kl_c;
        req.wdata.node = mem_rdata_i.node;
        req.wdata.pend = mem_rdata_i.pend ^ t_q;
        req.re         = 1'b1;
        req.raddr      = kr_c;
        state_d        = ST_PUSH1;
      end
      ST_PUSH1: begin
        req.we         = 1'b1;
        req.waddr      = kr_c;
        req.wdata.node = mem_rdata_i.node;
        req.wdata.pend = mem_rdata_i.pend ^ t_q;
        state_d        = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (out_q || cov_q) begin
          ret_d   = ((op_q == rxst_pkg::OP_QUERY) && out_q) ? '0 : nv_q;
          state_d = ST_RET;
        end else begin
          // descend into the left child
          stk_we    = 1'b1;
          stk_wa    = sp_q;
          stk_wd.k  = k_q;
          stk_wd.lo = lo_q;
          stk_wd.hi = hi_q;
          sp_d      = sp_q + 1'b1;
          k_d       = kl_c;
          hi_d      = mid_c;
          state_d   = ST_READ;
        end
      end
      ST_RET: begin
        if (sp_q == '0) begin
          if (op_q == rxst_pkg::OP_QUERY) begin
            res_valid_d = 1'b1;
            res_d       = ret_q;
          end
          state_d = ST_IDLE;
        end else if (!top.ph) begin
          // left child done, go right
          stk_we     = 1'b1;
          stk_wa     = sp_top;
          stk_wd     = top;
          stk_wd.acc = acc_c;
          stk_wd.ph  = 1'b1;
          k_d        = {top.k[rxst_pkg::NODE_BITS-2:0], 1'b1};
          lo_d       = tmid_c + 1'b1;
          hi_d       = top.hi;
          state_d    = ST_READ;
        end else begin
          // both children done, close the parent
          sp_d  = sp_top;
          ret_d = acc_c;
          if (op_q == rxst_pkg::OP_UPDATE) begin
            req.we         = 1'b1;
            req.waddr      = top.k;
            req.wdata.node = acc_c;
          end
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      sp_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      sp_q        <= sp_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    l_q   <= l_d;
    r_q   <= r_d;
    v_q   <= v_d;
    k_q   <= k_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    t_q   <= t_d;
    nv_q  <= nv_d;
    ret_q <= ret_d;
    out_q <= out_d;
    cov_q <= cov_d;
    res_q <= res_d;
  end

  // frame stack
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_q[stk_wa] <= stk_wd;
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_data_o  = res_q;
  assign mem_req_o   = req;

endmodule

// ===== src/range_xor_lazy_segment_tree.sv =====
// top level of the range xor segment tree with lazy marks
// depends on rxst_pkg, rxst_node_ram, rxst_walker and assert_macros.svh
//
//  channel   handshake                   payload
//  command   start, busy                 op, left_index, right_index, xor_value
//  result    range_xor_valid_o (strobe)  range_xor_o
//  config    cfg_valid_i, cfg_ready_o    cfg_data_i (element_count)
//
// after reset the node memory is cleared, one node a cycle, with busy held high
// each visited node is read, evaluated, written back and returned from; its mark is
// pushed to its children when it holds one and is no leaf; an item visits up to about
// 40 nodes, each step bound by the single read and single write port of the node memory
// results leave as a one-cycle strobe the cycle after the walk ends
module range_xor_lazy_segment_tree (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            op_i,
  input  logic [rxst_pkg::IDX_BITS-1:0]   left_index_i,
  input  logic [rxst_pkg::IDX_BITS-1:0]   right_index_i,
  input  logic [rxst_pkg::VALUE_BITS-1:0] xor_value_i,
  output logic                            range_xor_valid_o,
  output logic [rxst_pkg::VALUE_BITS-1:0] range_xor_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rxst_pkg::CNT_BITS-1:0]   cfg_data_i
);

`include "assert_macros.svh"

  logic [rxst_pkg::CNT_BITS-1:0] count_q;
  logic [rxst_pkg::IDX_BITS-1:0] last;
  logic [rxst_pkg::CNT_BITS-1:0] count_m1;
  rxst_pkg::mem_req_t            mem_req;
  rxst_pkg::entry_t              mem_rdata;
  logic                          mem_clash;

  // element count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= rxst_pkg::CNT_BITS'(rxst_pkg::MAX_ELEMENTS);
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = !busy;

  // last element index, count clamped to the supported range
  assign count_m1 = count_q - 1'b1;
  always_comb begin
    if (count_q == '0) begin
      last = '0;
    end else if (count_q > rxst_pkg::CNT_BITS'(rxst_pkg::MAX_ELEMENTS)) begin
      last = rxst_pkg::IDX_BITS'(rxst_pkg::MAX_ELEMENTS - 1);
    end else begin
      last = count_m1[rxst_pkg::IDX_BITS-1:0];
    end
  end

  rxst_node_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  rxst_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .op_i        (op_i),
    .left_i      (left_index_i),
    .right_i     (right_index_i),
    .value_i     (xor_value_i),
    .last_i      (last),
    .busy_o      (busy),
    .res_valid_o (range_xor_valid_o),
    .res_data_o  (range_xor_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // read and write of one entry in the same cycle
  assign mem_clash = mem_req.re && mem_req.we && (mem_req.raddr == mem_req.waddr);

  // checks
  `RXST_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted word did not raise busy")
  `RXST_ASSERT_IMPL(a_res_after_walk, range_xor_valid_o, $past(busy), "result without a walk")
  `RXST_ASSERT(a_no_rw_clash, !mem_clash, "node read and write hit the same entry")

endmodule
